// ===== rtl/core/m3h_pkg.sv =====
// shared types, constants and helper functions of the murmur3 x64_128 stream hash
package m3h_pkg;

    // mixing constants
    localparam logic [63:0] MUL_K1 = 64'h87c37b91114253d5;
    localparam logic [63:0] MUL_K2 = 64'h4cf5ad432745937f;
    localparam logic [63:0] FIN_M1 = 64'hff51afd7ed558ccd;
    localparam logic [63:0] FIN_M2 = 64'hc4ceb9fe1a85ec53;
    localparam logic [63:0] ADD_H1 = 64'h0000000052dce729;
    localparam logic [63:0] ADD_H2 = 64'h0000000038495ab5;

    // default width of the message length counter
    localparam int unsigned LENGTH_BITS_DEF = 32;

    // input item layout
    localparam int unsigned IN_DATA_W = 136;
    localparam int unsigned COUNT_W   = 5;
    localparam logic [COUNT_W-1:0] FULL_COUNT = 5'd16;

    // queue between front and back
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // one classified block on its way to the back end
    typedef struct packed {
        logic [63:0]        lo;       // masked low word
        logic [63:0]        hi;       // masked high word
        logic [COUNT_W-1:0] add_len;  // bytes added to the length
        logic               full;     // full block round
        logic               last;     // finalize after this block
    } blk_t;

    // rotate left by a constant amount
    function automatic logic [63:0] rot_left(input logic [63:0] v, input int unsigned r);
        return (v << r) | (v >> (64 - r));
    endfunction

    // byte lane mask: lanes below n are kept
    function automatic logic [127:0] lane_mask(input logic [COUNT_W-1:0] n);
        logic [127:0] m;
        m = '0;
        for (int i = 0; i < 16; i++)
        begin
            m[8*i +: 8] = (COUNT_W'(i) < n) ? 8'hFF : 8'h00;
        end
        return m;
    endfunction

endpackage

// ===== rtl/core/murmur3_x64_128_stream_hash_unit.sv =====
// top level of the murmur3 x64_128 stream hash: seed register, front end, queue, back end
//
// Hashes a message sent as 16-byte blocks with MurmurHash3 x64_128 and returns the second
// 64-bit half of the hash once per message, after the block marked last has been processed. The
// multiplies by the mixing and finalization constants share one 32 x 32 multiplier that builds
// each 64-bit product from three partial products; this multiplier sets the rate. In the back end
// a full block gets key mixing and a block round, a short last block key mixing and tail mixing,
// and the last block of a message adds length fold and finalization before the hash appears.
// A front stage and a two-entry queue take new blocks while the back end is busy and while a
// hash waits on the output. The seed is sampled when the first block of a message starts;
// write it only while the unit is idle.
module murmur3_x64_128_stream_hash_unit #(
    parameter int unsigned LENGTH_BITS = m3h_pkg::LENGTH_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // seed register write
    input  logic                          cfg_we,
    input  logic [31:0]                   cfg_wdata,
    // block input
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [m3h_pkg::IN_DATA_W-1:0] s_tdata,   // word_low, word_high, byte_count, zero pad
    input  logic                          s_tlast,
    // hash output
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [63:0]                   m_tdata    // hash_value
);
    import m3h_pkg::*;

    logic [31:0] seed_reg;
    logic [31:0] seed_next;
    logic        push_valid;
    logic        push_ready;
    blk_t        push_entry;
    logic        pop_valid;
    logic        pop_ready;
    blk_t        pop_entry;

    // seed register
    assign seed_next = cfg_we ? cfg_wdata : seed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= '0;
        end
        else
        begin
            seed_reg <= seed_next;
        end
    end

    m3h_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    m3h_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    m3h_back #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .seed      (seed_reg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_entry (pop_entry),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule

// ===== rtl/core/m3h_front.sv =====
// front end: accepts items, classifies full or tail block and masks unused bytes
module m3h_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [m3h_pkg::IN_DATA_W-1:0]      s_tdata,
    input  logic                               s_tlast,
    output logic                               push_valid,
    input  logic                               push_ready,
    output m3h_pkg::blk_t                      push_entry
);
    import m3h_pkg::*;

    logic               valid_reg;
    logic               valid_next;
    blk_t               entry_reg;
    blk_t               entry_next;
    logic [COUNT_W-1:0] count_in;
    logic [COUNT_W-1:0] count_eff;
    logic [127:0]       mask;
    logic               accept;

    // classify: anything but a short last block counts as sixteen bytes
    always_comb
    begin
        count_in  = s_tdata[132:128];
        count_eff = (!s_tlast || count_in >= FULL_COUNT) ? FULL_COUNT : count_in;
        mask      = lane_mask(count_eff);
        entry_next.lo      = s_tdata[63:0] & mask[63:0];
        entry_next.hi      = s_tdata[127:64] & mask[127:64];
        entry_next.add_len = count_eff;
        entry_next.full    = (count_eff == FULL_COUNT);
        entry_next.last    = s_tlast;
    end

    assign s_tready   = !valid_reg || push_ready;
    assign accept     = s_tvalid && s_tready;
    assign valid_next = accept || (valid_reg && !push_ready);

    // holding stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // holding stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            entry_reg <= entry_next;
        end
    end

    assign push_valid = valid_reg;
    assign push_entry = entry_reg;

endmodule

// ===== rtl/core/m3h_queue.sv =====
// short queue of classified blocks between front and back end
module m3h_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  m3h_pkg::blk_t push_entry,
    output logic          pop_valid,
    input  logic          pop_ready,
    output m3h_pkg::blk_t pop_entry
);
    import m3h_pkg::*;

    blk_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_entry  = mem[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== rtl/core/m3h_mul.sv =====
// 64 x 64 multiply modulo 2^64 on one 32 x 32 multiplier, three partial products
module m3h_mul (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic        done,
    output logic [63:0] product
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_LL,
        PH_LH,
        PH_HL
    } phase_t;

    phase_t      phase_reg;
    phase_t      phase_next;
    logic        done_reg;
    logic        done_next;
    logic [63:0] a_reg;
    logic [63:0] b_reg;
    logic [63:0] acc_reg;
    logic [63:0] acc_next;
    logic [31:0] pa;
    logic [31:0] pb;
    logic [63:0] pp;

    // partial product operand select
    always_comb
    begin
        pa = (phase_reg == PH_HL) ? a_reg[63:32] : a_reg[31:0];
        pb = (phase_reg == PH_LH) ? b_reg[63:32] : b_reg[31:0];
        pp = 64'(pa) * 64'(pb);
    end

    // phase sequencing and accumulation
    always_comb
    begin
        phase_next = phase_reg;
        done_next  = 1'b0;
        acc_next   = acc_reg;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (start)
                begin
                    phase_next = PH_LL;
                end
            end
            PH_LL:
            begin
                acc_next   = pp;
                phase_next = PH_LH;
            end
            PH_LH:
            begin
                acc_next   = acc_reg + {pp[31:0], 32'h0};
                phase_next = PH_HL;
            end
            PH_HL:
            begin
                acc_next   = acc_reg + {pp[31:0], 32'h0};
                phase_next = PH_IDLE;
                done_next  = 1'b1;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            done_reg  <= 1'b0;
            acc_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
            acc_reg   <= acc_next;
        end
    end

    // operands
    always_ff @(posedge clk)
    begin
        if (phase_reg == PH_IDLE && start)
        begin
            a_reg <= a;
            b_reg <= b;
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

// ===== rtl/core/m3h_back.sv =====
// back end: block rounds, tail mixing, length fold and finalization on a shared multiplier
module m3h_back #(
    parameter int unsigned LENGTH_BITS = m3h_pkg::LENGTH_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [31:0]   seed,
    input  logic          pop_valid,
    output logic          pop_ready,
    input  m3h_pkg::blk_t pop_entry,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [63:0]   out_data
);
    import m3h_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_K1A,
        ST_K1B,
        ST_K2A,
        ST_K2B,
        ST_R1A,
        ST_R1B,
        ST_R2A,
        ST_R2B,
        ST_TAIL,
        ST_FLEN,
        ST_FADD1,
        ST_FADD2,
        ST_FX1,
        ST_FM1A,
        ST_FM1B,
        ST_FX2,
        ST_FM2A,
        ST_FM2B,
        ST_FADD3,
        ST_FADD4,
        ST_OUT
    } state_t;

    state_t                 state_reg;
    state_t                 state_next;
    logic                   in_msg_reg;
    logic                   in_msg_next;
    logic                   issued_reg;
    logic                   issued_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [63:0]            out_data_reg;
    logic [63:0]            out_data_next;
    logic [63:0]            h1_reg;
    logic [63:0]            h1_next;
    logic [63:0]            h2_reg;
    logic [63:0]            h2_next;
    logic [63:0]            lo_reg;
    logic [63:0]            lo_next;
    logic [63:0]            hi_reg;
    logic [63:0]            hi_next;
    logic                   full_reg;
    logic                   full_next;
    logic                   last_reg;
    logic                   last_next;
    logic [LENGTH_BITS-1:0] total_reg;
    logic [LENGTH_BITS-1:0] total_next;
    logic                   mul_start;
    logic [63:0]            mul_a;
    logic [63:0]            mul_b;
    logic                   mul_done;
    logic [63:0]            mul_p;
    logic                   mul_state;
    logic [63:0]            len64;

    m3h_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    assign len64 = 64'(total_reg);

    // multiplier operand select per state
    always_comb
    begin
        mul_state = 1'b1;
        mul_a     = lo_reg;
        mul_b     = MUL_K1;
        unique case (state_reg)
            ST_K1A:
            begin
                mul_a = lo_reg;
                mul_b = MUL_K1;
            end
            ST_K1B:
            begin
                mul_a = lo_reg;
                mul_b = MUL_K2;
            end
            ST_K2A:
            begin
                mul_a = hi_reg;
                mul_b = MUL_K2;
            end
            ST_K2B:
            begin
                mul_a = hi_reg;
                mul_b = MUL_K1;
            end
            ST_FM1A:
            begin
                mul_a = h1_reg;
                mul_b = FIN_M1;
            end
            ST_FM1B:
            begin
                mul_a = h1_reg;
                mul_b = FIN_M2;
            end
            ST_FM2A:
            begin
                mul_a = h2_reg;
                mul_b = FIN_M1;
            end
            ST_FM2B:
            begin
                mul_a = h2_reg;
                mul_b = FIN_M2;
            end
            default:
            begin
                mul_state = 1'b0;
            end
        endcase
        mul_start = mul_state && !issued_reg;
    end

    // sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        in_msg_next    = in_msg_reg;
        issued_next    = issued_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        h1_next        = h1_reg;
        h2_next        = h2_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        full_next      = full_reg;
        last_next      = last_reg;
        total_next     = total_reg;
        pop_ready      = 1'b0;

        // multiply handshake
        if (mul_state)
        begin
            if (!issued_reg)
            begin
                issued_next = 1'b1;
            end
            else if (mul_done)
            begin
                issued_next = 1'b0;
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                pop_ready = 1'b1;
                if (pop_valid)
                begin
                    lo_next     = pop_entry.lo;
                    hi_next     = pop_entry.hi;
                    full_next   = pop_entry.full;
                    last_next   = pop_entry.last;
                    in_msg_next = 1'b1;
                    if (!in_msg_reg)
                    begin
                        h1_next    = 64'(seed);
                        h2_next    = 64'(seed);
                        total_next = LENGTH_BITS'(pop_entry.add_len);
                    end
                    else
                    begin
                        total_next = total_reg + LENGTH_BITS'(pop_entry.add_len);
                    end
                    state_next = ST_K1A;
                end
            end
            ST_K1A:
            begin
                if (issued_reg && mul_done)
                begin
                    lo_next    = rot_left(mul_p, 31);
                    state_next = ST_K1B;
                end
            end
            ST_K1B:
            begin
                if (issued_reg && mul_done)
                begin
                    lo_next    = mul_p;
                    state_next = ST_K2A;
                end
            end
            ST_K2A:
            begin
                if (issued_reg && mul_done)
                begin
                    hi_next    = rot_left(mul_p, 33);
                    state_next = ST_K2B;
                end
            end
            ST_K2B:
            begin
                if (issued_reg && mul_done)
                begin
                    hi_next    = mul_p;
                    state_next = full_reg ? ST_R1A : ST_TAIL;
                end
            end
            // block round, first half
            ST_R1A:
            begin
                h1_next    = rot_left(h1_reg ^ lo_reg, 27) + h2_reg;
                state_next = ST_R1B;
            end
            ST_R1B:
            begin
                h1_next    = h1_reg + {h1_reg[61:0], 2'b00} + ADD_H1;
                state_next = ST_R2A;
            end
            // block round, second half
            ST_R2A:
            begin
                h2_next    = rot_left(h2_reg ^ hi_reg, 31) + h1_reg;
                state_next = ST_R2B;
            end
            ST_R2B:
            begin
                h2_next    = h2_reg + {h2_reg[61:0], 2'b00} + ADD_H2;
                state_next = last_reg ? ST_FLEN : ST_IDLE;
            end
            // tail mixing, unused lanes already zero
            ST_TAIL:
            begin
                h1_next    = h1_reg ^ lo_reg;
                h2_next    = h2_reg ^ hi_reg;
                state_next = last_reg ? ST_FLEN : ST_IDLE;
            end
            // length fold
            ST_FLEN:
            begin
                h1_next    = h1_reg ^ len64;
                h2_next    = h2_reg ^ len64;
                state_next = ST_FADD1;
            end
            ST_FADD1:
            begin
                h1_next    = h1_reg + h2_reg;
                state_next = ST_FADD2;
            end
            ST_FADD2:
            begin
                h2_next    = h2_reg + h1_reg;
                state_next = ST_FX1;
            end
            // fmix64 on first half
            ST_FX1:
            begin
                h1_next    = h1_reg ^ (h1_reg >> 33);
                state_next = ST_FM1A;
            end
            ST_FM1A:
            begin
                if (issued_reg && mul_done)
                begin
                    h1_next    = mul_p ^ (mul_p >> 33);
                    state_next = ST_FM1B;
                end
            end
            ST_FM1B:
            begin
                if (issued_reg && mul_done)
                begin
                    h1_next    = mul_p ^ (mul_p >> 33);
                    state_next = ST_FX2;
                end
            end
            // fmix64 on second half
            ST_FX2:
            begin
                h2_next    = h2_reg ^ (h2_reg >> 33);
                state_next = ST_FM2A;
            end
            ST_FM2A:
            begin
                if (issued_reg && mul_done)
                begin
                    h2_next    = mul_p ^ (mul_p >> 33);
                    state_next = ST_FM2B;
                end
            end
            ST_FM2B:
            begin
                if (issued_reg && mul_done)
                begin
                    h2_next    = mul_p ^ (mul_p >> 33);
                    state_next = ST_FADD3;
                end
            end
            ST_FADD3:
            begin
                h1_next    = h1_reg + h2_reg;
                state_next = ST_FADD4;
            end
            ST_FADD4:
            begin
                h2_next    = h2_reg + h1_reg;
                state_next = ST_OUT;
            end
            // hand the hash to the output register, end of message
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = h2_reg;
                    in_msg_next    = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            in_msg_reg    <= 1'b0;
            issued_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            in_msg_reg    <= in_msg_next;
            issued_reg    <= issued_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    // working values
    always_ff @(posedge clk)
    begin
        h1_reg       <= h1_next;
        h2_reg       <= h2_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        full_reg     <= full_next;
        last_reg     <= last_next;
        total_reg    <= total_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
